// File: hdl/hcs_pkg.sv
// Shared constants and types for the Hamiltonian cycle search core.
package hcs_pkg;

  // Fixed field widths of the item channels.
  localparam int ROW_W          = 16;
  localparam int OUT_VERTEX_W   = 4;
  localparam int VCOUNT_W       = 5;

  // Default graph capacity and reset value of the vertex count register.
  localparam int MAX_VERTS_DEF  = 16;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

  // Configuration port geometry: one 32-bit register per word.
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = CFG_ADDR_W - 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_EMIT
  } hcs_state_t;

endpackage

// File: hdl/hcs_lane.sv
// One candidate lane: decides whether its vertex may extend the current path.
module hcs_lane #(
  parameter int MAX_VERTS = hcs_pkg::MAX_VERTS_DEF,
  parameter int LANE_IDX  = 0,
  parameter int DW        = $clog2(MAX_VERTS + 1)
) (
  input  logic          edge_bit,
  input  logic          used_bit,
  input  logic [DW-1:0] start,
  input  logic [DW-1:0] count,
  output logic          ok
);
  import hcs_pkg::*;

  localparam logic [DW-1:0] LANE_V = DW'(LANE_IDX);

  // The lane is a candidate if it is adjacent, still free and inside the
  // window from the resume point up to the vertex count.
  assign ok = edge_bit && !used_bit && (LANE_V >= start) && (LANE_V < count);

endmodule

// File: hdl/hcs_merge.sv
// Merging stage: picks the lowest-numbered lane that reported a candidate.
module hcs_merge #(
  parameter int MAX_VERTS = hcs_pkg::MAX_VERTS_DEF,
  parameter int VW        = $clog2(MAX_VERTS)
) (
  input  logic [MAX_VERTS-1:0] lane_ok,
  output logic                 hit,
  output logic [VW-1:0]        pick
);
  import hcs_pkg::*;

  assign hit = |lane_ok;

  always_comb begin
    pick = '0;
    for (int k = MAX_VERTS - 1; k >= 0; k--) begin
      if (lane_ok[k]) begin
        pick = VW'(k);
      end
    end
  end

endmodule

// File: hdl/hamiltonian_cycle_search_core.sv
// Top level of the Hamiltonian cycle search core: row loading, search and emission.
// Rows load one item per cycle while the input is valid, then the search runs one step
// at a time (each step either extends the path or backtracks one level), then results
// go out one per cycle while the receiver is ready: n+1 results when a cycle is found,
// a single result otherwise. Search time depends on the graph and is bounded by the backtracking tree size.
// Synchronous active-low reset sets the vertex count to 16 and empties the loader.
module hamiltonian_cycle_search_core #(
  parameter int MAX_VERTS = hcs_pkg::MAX_VERTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Row input channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hcs_pkg::ROW_W-1:0]      in_adjacency_row,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [hcs_pkg::OUT_VERTEX_W-1:0] out_vertex,
  output logic                           out_last,
  // Configuration port.
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import hcs_pkg::*;

  // Vertex index width and depth width (depth runs from 0 up to MAX_VERTS).
  localparam int VW = $clog2(MAX_VERTS);
  localparam int DW = $clog2(MAX_VERTS + 1);

  hcs_state_t state_r, state_nxt;

  logic [VCOUNT_W-1:0] vcount_r;
  logic [DW-1:0]       n_eff;

  // Adjacency rows, the path stack and the per-depth resume points are
  // flip-flop arrays; each is read at a single address chosen by the controller.
  logic [ROW_W-1:0]    adj_r [MAX_VERTS];
  logic [VW-1:0]       ps_r  [MAX_VERTS];
  logic [DW-1:0]       nc_r  [MAX_VERTS+1];

  logic [VW-1:0]        rows_r;
  logic [MAX_VERTS-1:0] used_r;
  logic [DW-1:0]        depth_r;
  logic [DW-1:0]        emit_r;
  logic                 found_r;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;

  logic                 load_fire;
  logic                 last_row;
  logic                 out_fire;

  logic [VW-1:0]        ps_raddr;
  logic [VW-1:0]        ps_rd;
  logic [ROW_W-1:0]     row_rd;
  logic [DW-1:0]        start;
  logic [MAX_VERTS-1:0] lane_ok;
  logic                 hit;
  logic [VW-1:0]        pick;

  logic                 at_full;
  logic                 found_evt;
  logic                 advance;
  logic [DW-1:0]        depth_dec;
  logic                 fail;

  // ---------------------------------------------------------------------------
  // Configuration port. The only register is the vertex count at word zero;
  // writes to other words are ignored and read back as zero.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_idx == REG_VERTEX_COUNT);

  always_comb begin
    if (cfg_idx == REG_VERTEX_COUNT) begin
      cfg_prdata = CFG_DATA_W'(vcount_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // A count of zero behaves as one vertex; counts beyond the capacity saturate.
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = DW'(1);
    end else if (32'(vcount_r) > MAX_VERTS) begin
      n_eff = DW'(MAX_VERTS);
    end else begin
      n_eff = DW'(vcount_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes.
  // ---------------------------------------------------------------------------
  assign load_fire = in_valid && in_ready;
  assign last_row  = (rows_r == VW'(n_eff - DW'(1)));
  assign out_fire  = out_valid && out_ready;

  // ---------------------------------------------------------------------------
  // Search datapath. The path stack is read at the top of the path while
  // searching and at the emission index while results go out. The top vertex
  // selects one adjacency row, which feeds one lane per vertex.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state_r == ST_EMIT) begin
      ps_raddr = (emit_r < n_eff) ? VW'(emit_r) : '0;
    end else begin
      ps_raddr = VW'(depth_r - DW'(1));
    end
  end

  assign ps_rd  = ps_r[ps_raddr];
  assign row_rd = adj_r[ps_rd];
  assign start  = nc_r[depth_r];

  for (genvar v = 0; v < MAX_VERTS; v++) begin : g_lane
    logic edge_bit;
    if (v < ROW_W) begin : g_row
      assign edge_bit = row_rd[v];
    end else begin : g_none
      // Vertices beyond the row width have no edges at all.
      assign edge_bit = 1'b0;
    end
    hcs_lane #(
      .MAX_VERTS (MAX_VERTS),
      .LANE_IDX  (v),
      .DW        (DW)
    ) u_lane (
      .edge_bit (edge_bit),
      .used_bit (used_r[v]),
      .start    (start),
      .count    (n_eff),
      .ok       (lane_ok[v])
    );
  end

  hcs_merge #(
    .MAX_VERTS (MAX_VERTS),
    .VW        (VW)
  ) u_merge (
    .lane_ok (lane_ok),
    .hit     (hit),
    .pick    (pick)
  );

  // When the path holds every vertex, the row of its last vertex decides
  // whether the edge back to vertex zero closes the cycle. Otherwise the lowest
  // free neighbour extends the path, and with none left the search backtracks.
  assign at_full   = (depth_r >= n_eff);
  assign found_evt = at_full && row_rd[0];
  assign advance   = !at_full && hit;
  assign depth_dec = depth_r - DW'(1);
  assign fail      = !found_evt && !advance && (depth_dec == '0);

  // ---------------------------------------------------------------------------
  // Controller.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (load_fire && last_row) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (found_evt || fail) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire && out_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD:   in_ready  = 1'b1;
      ST_SEARCH: in_ready  = 1'b0;
      ST_EMIT:   out_valid = 1'b1;
      default:   in_ready  = 1'b0;
    endcase
  end

  // Result fields come straight from the path stack; the closing result reads
  // entry zero, which always holds vertex zero.
  assign out_found  = found_r;
  assign out_vertex = found_r ? OUT_VERTEX_W'(ps_rd) : '0;
  assign out_last   = !found_r || (emit_r == n_eff);

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      vcount_r <= VCOUNT_RST;
      rows_r   <= '0;
      used_r   <= '0;
      depth_r  <= '0;
      emit_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_pwdata[VCOUNT_W-1:0];
        rows_r   <= '0;
      end else if (load_fire) begin
        if (last_row) begin
          rows_r  <= '0;
          used_r  <= MAX_VERTS'(1);
          depth_r <= DW'(1);
        end else begin
          rows_r <= rows_r + VW'(1);
        end
      end
      if (state_r == ST_SEARCH) begin
        if (found_evt) begin
          found_r <= 1'b1;
          emit_r  <= '0;
        end else if (advance) begin
          used_r[pick] <= 1'b1;
          depth_r      <= depth_r + DW'(1);
        end else begin
          depth_r <= depth_dec;
          if (fail) begin
            found_r <= 1'b0;
            emit_r  <= '0;
          end else begin
            used_r[ps_rd] <= 1'b0;
          end
        end
      end
      if (out_fire && !out_last) begin
        emit_r <= emit_r + DW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Storage arrays: no reset, every entry the search uses is written before it is used.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_fire) begin
      adj_r[rows_r] <= in_adjacency_row;
      if (last_row) begin
        ps_r[0] <= '0;
        nc_r[1] <= DW'(1);
      end
    end
    if (state_r == ST_SEARCH && !found_evt && advance) begin
      ps_r[VW'(depth_r)]        <= pick;
      nc_r[depth_r]             <= DW'(pick) + DW'(1);
      nc_r[depth_r + DW'(1)]    <= DW'(1);
    end
  end

endmodule

// File: tb/hamiltonian_cycle_search_core_tb.sv
// Self-checking testbench for the Hamiltonian cycle search core.
`timescale 1ns / 100ps

module hamiltonian_cycle_search_core_tb;
  import hcs_pkg::*;

  localparam int      MAX_VERTS      = MAX_VERTS_DEF;
  localparam realtime CLK_PERIOD     = 12.0;
  localparam int      RANDOM_ROWS    = 440;
  // Random graphs are redrawn until the backtracking effort is within this, so
  // that no single search runs away with the cycle budget.
  localparam int      SEARCH_BUDGET  = 1500;
  localparam int      EFFORT_CEILING = 32'h3FFF_FFFF;
  localparam int      SETTLE_CYCLES  = 4;
  localparam int      TAIL_CYCLES    = 50;
  localparam int      CYCLE_LIMIT    = 1_000_000;
  localparam int      REPORT_LIMIT   = 10;

  // The second register slot is not mapped; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 1'd1;

  typedef logic [ROW_W-1:0]                          row_t;
  typedef logic [VCOUNT_W-1:0]                       count_t;
  typedef logic [OUT_VERTEX_W-1:0]                   vertex_t;
  typedef logic [MAX_VERTS-1:0][ROW_W-1:0]           matrix_t;
  typedef logic [MAX_VERTS:0][OUT_VERTEX_W-1:0]      route_t;

  typedef struct packed {
    logic    found;
    vertex_t vertex;
    logic    last;
  } tour_step_t;

  // How the results of a matrix-closing row are worked out: by the predictor,
  // or typed in from the table as a miss or as the cycle 0, 1, ..., n-1, 0.
  typedef enum logic [1:0] {WANT_MODEL, WANT_MISS, WANT_LOOP} verdict_t;
  typedef enum logic [1:0] {STEP_ROW, STEP_SET_COUNT, STEP_SET_UNMAPPED} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    row_t       value;
    logic [4:0] reps;
    verdict_t   want;
  } plan_step_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  row_t in_adjacency_row = '0;
  logic out_ready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;

  logic in_ready;
  logic out_valid;
  logic out_found;
  vertex_t out_vertex;
  logic out_last;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Travels alongside the row payload so that the monitor knows, at the edge
  // where the row is taken, whether its results come from the table.
  verdict_t row_hint = WANT_MODEL;

  // Predictor state: the register copy, the rows taken so far and the expected
  // results still waiting to be seen.
  count_t       count_model = VCOUNT_RST;
  matrix_t      graph = '0;
  int           rows_held = 0;
  tour_step_t   tour_q [$];

  int faults = 0;
  int cycle_count = 0;
  int feed_idle_pct = 10;
  int drain_stall_pct = 54;

  plan_step_t plan [$];

  hamiltonian_cycle_search_core #(.MAX_VERTS(MAX_VERTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_adjacency_row (in_adjacency_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_vertex       (out_vertex),
    .out_last         (out_last),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Watchdog: a hung handshake or a runaway search ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The result side stalls at random, at whatever rate the current phase sets.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= drain_stall_pct);
  end

  // A register value of zero behaves as one vertex, and anything above the
  // capacity is clipped to it.
  function automatic int span(input count_t raw);
    if (raw == 0) return 1;
    if (raw > MAX_VERTS) return MAX_VERTS;
    return int'(raw);
  endfunction

  // Depth-first search for a cycle through all n vertices starting at vertex 0.
  // Candidates are tried lowest first, and a full path only counts when its
  // last vertex leads back to vertex 0. The effort figure counts search steps
  // and candidate checks; the search gives up once it passes the cap.
  function automatic bit trace_cycle(input int n, input matrix_t g, input int cap,
                                     output route_t route, output int effort);
    logic [MAX_VERTS-1:0] used;
    int nxt [MAX_VERTS+1];
    int depth;
    int v;
    int prev;
    bit moved;
    route = '0;
    foreach (nxt[i]) nxt[i] = 0;
    used = 1;
    depth = 1;
    nxt[1] = 1;
    effort = 0;
    while (effort <= cap) begin
      effort++;
      moved = 1'b0;
      if (depth < n) begin
        prev = int'(route[depth-1]);
        for (v = nxt[depth]; v < n && !moved; v++) begin
          effort++;
          if (g[prev][v] && !used[v]) begin
            route[depth] = vertex_t'(v);
            nxt[depth] = v + 1;
            used[v] = 1'b1;
            depth++;
            if (depth <= MAX_VERTS) nxt[depth] = 1;
            moved = 1'b1;
          end
        end
      end else if (g[route[n-1]][0]) begin
        return 1'b1;
      end
      if (!moved) begin
        depth--;
        if (depth == 0) return 1'b0;
        used[route[depth]] = 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic void log_fault(input string msg);
    faults++;
    if (faults <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Takes one accepted row into the predictor. The row that completes the
  // matrix starts the search and queues every result it should produce.
  task automatic absorb_row(input row_t row, input verdict_t want);
    int n;
    int i;
    int effort;
    bit hit;
    route_t route;
    tour_step_t item;
    n = span(count_model);
    if (rows_held >= n) rows_held = 0;
    graph[rows_held] = row;
    rows_held++;
    if (rows_held < n) return;
    rows_held = 0;
    hit = trace_cycle(n, graph, EFFORT_CEILING, route, effort);
    if (want == WANT_MISS || (want == WANT_MODEL && !hit)) begin
      item.found = 1'b0;
      item.vertex = '0;
      item.last = 1'b1;
      tour_q.push_back(item);
    end else begin
      for (i = 0; i <= n; i++) begin
        item.found = 1'b1;
        item.last = (i == n);
        if (want == WANT_LOOP) item.vertex = (i < n) ? vertex_t'(i) : '0;
        else item.vertex = (i < n) ? route[i] : route[0];
        tour_q.push_back(item);
      end
    end
  endtask

  task automatic match_result(input tour_step_t got);
    tour_step_t want;
    if (tour_q.size() == 0) begin
      log_fault($sformatf("unexpected result: found=%0d vertex=%0d last=%0d",
                          got.found, got.vertex, got.last));
      return;
    end
    want = tour_q.pop_front();
    if (got.found !== want.found || got.vertex !== want.vertex || got.last !== want.last)
      log_fault($sformatf(
          "result mismatch: expected found=%0d vertex=%0d last=%0d, got %0d %0d %0d",
          want.found, want.vertex, want.last,
          got.found, got.vertex, got.last));
  endtask

  // Monitor: follows register writes and accepted rows into the predictor, and
  // checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_VERTEX_COUNT) begin
        count_model <= cfg_pwdata[VCOUNT_W-1:0];
        rows_held <= 0;
      end
      if (in_valid && in_ready) absorb_row(in_adjacency_row, row_hint);
      if (out_valid && out_ready) match_result({out_found, out_vertex, out_last});
    end
  end

  // Presents one row, sometimes after a short gap, and holds it until taken.
  task automatic send_row(input row_t row, input verdict_t want);
    if ($urandom_range(99) < feed_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adjacency_row <= row;
    row_hint <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Register writes wait until no result is outstanding: every expected result
  // has drained, and then the SETTLE_CYCLES wait lets the controller settle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tour_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Reads the vertex count back; only the register's own five bits are compared.
  // The port idles first, so that a read never follows a write in the same cycle.
  task automatic check_count_reg();
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= {REG_VERTEX_COUNT, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[VCOUNT_W-1:0] !== count_model)
      log_fault($sformatf("vertex count readback: expected %0d, got %0d",
                          count_model, cfg_prdata[VCOUNT_W-1:0]));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic plan_step_t plan_entry(input step_kind_t kind, input row_t value,
                                            input int reps, input verdict_t want);
    plan_step_t s;
    s.kind = kind;
    s.value = value;
    s.reps = reps[4:0];
    s.want = want;
    return s;
  endfunction

  // Random vertex counts lean towards small graphs; now and then the full
  // size, including the saturating values, and the degenerate zero and one.
  function automatic count_t pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 6) return count_t'($urandom_range(31, 16));
    if (r < 14) return count_t'($urandom_range(15, 9));
    if (r < 20) return count_t'($urandom_range(1, 0));
    return count_t'($urandom_range(8, 2));
  endfunction

  // Lays a Hamiltonian cycle through a shuffled order of the vertices, so that
  // the search has something to find however sparse the rest of the graph is.
  function automatic void plant_ring(input int n, inout matrix_t g);
    int order [MAX_VERTS];
    int i;
    int k;
    int t;
    for (i = 0; i < n; i++) order[i] = i;
    for (i = n - 1; i >= 2; i--) begin
      k = $urandom_range(i, 1);
      t = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    for (i = 0; i < n; i++) g[order[i]][order[(i + 1) % n]] = 1'b1;
  endfunction

  // Draws a random graph of n vertices in one of several shapes and keeps it
  // only if the search finishes within budget. Bits beyond the graph are left
  // as noise, which the block has to ignore.
  task automatic build_graph(input int n, output matrix_t g);
    matrix_t trial;
    route_t scrap;
    int effort;
    int density;
    int style;
    int tries;
    int i;
    int j;
    for (tries = 0; tries < 40; tries++) begin
      style = $urandom_range(3);
      density = $urandom_range(90, 15);
      foreach (trial[r]) trial[r] = row_t'($urandom);
      for (i = 0; i < n; i++) begin
        for (j = 0; j < n; j++) begin
          case (style)
            0: trial[i][j] = ($urandom_range(99) < density);
            1: trial[i][j] = ($urandom_range(99) < density / 4);
            2: if (j >= i) begin
              trial[i][j] = ($urandom_range(99) < density);
              trial[j][i] = trial[i][j];
            end
            default: ;
          endcase
        end
      end
      if (style == 1) plant_ring(n, trial);
      void'(trace_cycle(n, trial, SEARCH_BUDGET, scrap, effort));
      if (effort <= SEARCH_BUDGET) begin
        g = trial;
        return;
      end
    end
    // Nothing cheap enough turned up: fall back to a bare ring.
    foreach (trial[r]) trial[r] = row_t'($urandom);
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++) trial[i][j] = 1'b0;
    plant_ring(n, trial);
    g = trial;
  endtask

  initial begin
    int r;
    int k;
    int n;
    int cut;
    int bad_at;
    int rows_sent;
    bit first;
    count_t cur_count;
    matrix_t g;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_count_reg();

    // Directed table. The reset count of sixteen is used straight away with a
    // complete graph, whose cycle is simply every vertex in order. Then a count
    // of zero acting as one vertex, the single vertex with and without its
    // self-loop, an empty graph, a count write in the middle of a matrix that
    // throws the loaded row away, and a write to the unmapped slot that must
    // leave both the count and the row position alone.
    plan.push_back(plan_entry(STEP_ROW,          16'hFFFF, 16, WANT_LOOP));
    plan.push_back(plan_entry(STEP_SET_COUNT,    16'h0000, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'hFFFE, 1,  WANT_MISS));
    plan.push_back(plan_entry(STEP_SET_COUNT,    16'h0001, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0001, 1,  WANT_LOOP));
    plan.push_back(plan_entry(STEP_SET_COUNT,    16'h0002, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0000, 2,  WANT_MISS));
    plan.push_back(plan_entry(STEP_SET_COUNT,    16'h0003, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'hFFFF, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_SET_COUNT,    16'h0003, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0004, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0001, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0002, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_SET_UNMAPPED, 16'h001F, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0002, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0004, 1,  WANT_MODEL));
    plan.push_back(plan_entry(STEP_ROW,          16'h0001, 1,  WANT_LOOP));

    foreach (plan[s]) begin
      case (plan[s].kind)
        STEP_ROW: begin
          for (r = 0; r < plan[s].reps; r++) send_row(plan[s].value, plan[s].want);
        end
        STEP_SET_COUNT: begin
          write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(plan[s].value));
          check_count_reg();
        end
        default: begin
          write_reg(IDX_UNMAPPED, CFG_DATA_W'(plan[s].value));
          check_count_reg();
        end
      endcase
    end

    // Random part: whole matrices with random content, the count changing now
    // and then. A few matrices are cut short and restarted by a count write,
    // and a few have an ignored write to the unmapped slot between rows.
    // Idling runs in three phases: a slow receiver, then a slow sender, then
    // neither idles.
    rows_sent = 0;
    first = 1'b1;
    cur_count = '0;
    while (rows_sent < RANDOM_ROWS) begin
      if (rows_sent < RANDOM_ROWS / 3) begin
        feed_idle_pct = 10;
        drain_stall_pct = 54;
      end else if (rows_sent < 2 * RANDOM_ROWS / 3) begin
        feed_idle_pct = 54;
        drain_stall_pct = 10;
      end else begin
        feed_idle_pct = 0;
        drain_stall_pct = 0;
      end
      if (first || $urandom_range(99) < 30) begin
        cur_count = pick_count();
        write_reg(REG_VERTEX_COUNT, {$urandom} & ~32'h1F | CFG_DATA_W'(cur_count));
        check_count_reg();
        first = 1'b0;
      end
      n = span(cur_count);
      build_graph(n, g);
      if (n > 1 && $urandom_range(99) < 10) begin
        cut = $urandom_range(n - 1, 1);
        for (k = 0; k < cut; k++) begin
          send_row(row_t'($urandom), WANT_MODEL);
          rows_sent++;
        end
        write_reg(REG_VERTEX_COUNT, {$urandom} & ~32'h1F | CFG_DATA_W'(cur_count));
      end
      bad_at = ($urandom_range(99) < 8) ? int'($urandom_range(n - 1, 0)) : -1;
      for (k = 0; k < n; k++) begin
        if (k == bad_at) write_reg(IDX_UNMAPPED, $urandom);
        send_row(g[k], WANT_MODEL);
        rows_sent++;
      end
    end

    // Drain: every expected result must arrive, and nothing more after it.
    in_valid <= 1'b0;
    @(posedge clk);
    while (tour_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && tour_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
